// ===== hdl/rarmt_pkg.sv =====
// rarmt_pkg: transaction types and sequencer codes for the range add / range max tree.
// Used by: range_add_range_max_tree, rarmt_checker, range_add_range_max_tree_tb.
// Depends on: nothing.
`timescale 1ns / 1ps
`default_nettype none
package rarmt_pkg;

  localparam int IN_IDX_W = 10;
  localparam int FIELD_W  = 48;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [IN_IDX_W-1:0]       range_low;
    logic [IN_IDX_W-1:0]       range_high;
    logic signed [FIELD_W-1:0] delta;
  } in_t;

  typedef struct packed {
    logic                      answer_kind;
    logic signed [FIELD_W-1:0] max_value;
  } out_t;

  // Sequencer states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_CLR  = 4'd1;
  localparam logic [ST_W-1:0] ST_RD   = 4'd2;
  localparam logic [ST_W-1:0] ST_EV   = 4'd3;
  localparam logic [ST_W-1:0] ST_CRD0 = 4'd4;
  localparam logic [ST_W-1:0] ST_CWR0 = 4'd5;
  localparam logic [ST_W-1:0] ST_CRD1 = 4'd6;
  localparam logic [ST_W-1:0] ST_CWR1 = 4'd7;
  localparam logic [ST_W-1:0] ST_POST = 4'd8;
  localparam logic [ST_W-1:0] ST_RET  = 4'd9;

  // Node classification against the requested range
  localparam logic [1:0] K_DISJ = 2'd0;
  localparam logic [1:0] K_COV  = 2'd1;
  localparam logic [1:0] K_PART = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/rarmt_mem.sv =====
// rarmt_mem: node max and pending add arrays, one shared write address, one read address.
// Read data registered. Depends on: nothing.
`timescale 1ns / 1ps
`default_nettype none
module rarmt_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int VB    = 48
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output logic [VB-1:0]      rd_max,
  output logic [VB-1:0]      rd_pend,
  input  wire logic          we_max,
  input  wire logic          we_pend,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [VB-1:0] wd_max,
  input  wire logic [VB-1:0] wd_pend
);

  logic [VB-1:0] max_mem  [DEPTH];
  logic [VB-1:0] pend_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_max) begin
      max_mem[wr_addr] <= wd_max;
    end
    if (we_pend) begin
      pend_mem[wr_addr] <= wd_pend;
    end
    rd_max  <= max_mem[rd_addr];
    rd_pend <= pend_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/range_add_range_max_tree.sv =====
// range_add_range_max_tree: lazy segment tree, range add and range max over signed slots.
// Depends on: rarmt_pkg, rarmt_mem.
//
// Usage
// - Input: present in_data and raise start; the transaction is taken on an edge
//   with start high and busy low. mode 0 adds delta (saturating) to slots
//   range_low..range_high, mode 1 asks for their maximum.
// - Result: every transaction not cut short by a config write gives one
//   result, shown for one cycle with out_strobe high. answer_kind follows mode;
//   max_value is the maximum on a query (most negative value for an empty
//   range), zero on an add. The receiver cannot stall; a result is never held back.
// - Config: cfg_data (last_index, clamped to SLOTS-1) is taken whenever
//   cfg_valid is high (cfg_ready is always high). Every write restarts the
//   store clearing pass, since the tree shape changes.
// - Reset: rst_n low clears control, sets last_index to min(1023, SLOTS-1) and
//   then runs a clearing pass over all 2*SLOTS nodes, busy high.
// - Walk: one transaction at a time. The walk is a sequencer around the
//   node memories: each visited node is read, evaluated and written back,
//   classified and returned, with a read per child and a write per existing
//   child added when a pending add is pushed into its children. A walk
//   visits up to about 4*log2(SLOTS) nodes.
//   The result strobe comes on the cycle busy falls.
`timescale 1ns / 1ps
`default_nettype none
module range_add_range_max_tree #(
  parameter int SLOTS      = 1024,
  parameter int VALUE_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rarmt_pkg::in_t                in_data,
  output logic                               out_strobe,
  output rarmt_pkg::out_t                    out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rarmt_pkg::IN_IDX_W-1:0] cfg_data
);

  localparam int VB    = VALUE_BITS;
  localparam int IB    = $clog2(SLOTS);
  localparam int NODES = 2 * SLOTS;
  localparam int NB    = $clog2(NODES);
  localparam int NW    = NB + 1;
  localparam int CW    = (IB > rarmt_pkg::IN_IDX_W) ? IB : rarmt_pkg::IN_IDX_W;
  localparam int DEPTH = IB + 1;
  localparam int SPW   = $clog2(DEPTH + 1);
  localparam int STK   = 1 << SPW;
  localparam int LI_RST = (SLOTS - 1 < 1023) ? SLOTS - 1 : 1023;

  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [63:0] VMAX64 = 64'(VMAX);
  localparam logic signed [63:0] VMIN64 = 64'(VMIN);
  localparam logic signed [63:0] FMAX64 = 64'sd140737488355327;
  localparam logic signed [63:0] FMIN64 = -FMAX64 - 64'sd1;

  function automatic logic signed [VB-1:0] sat_add(input logic signed [VB-1:0] a,
                                                   input logic signed [VB-1:0] b);
    logic signed [VB:0] s;
    s = {a[VB-1], a} + {b[VB-1], b};
    if (s[VB] != s[VB-1]) begin
      return s[VB] ? VMIN : VMAX;
    end
    return s[VB-1:0];
  endfunction

  // control
  logic [rarmt_pkg::ST_W-1:0] st_r;
  logic [NW-1:0]              clr_r;
  logic [IB-1:0]              li_r;
  rarmt_pkg::in_t             in_r;
  logic signed [VB-1:0]       d_r;

  // current node
  logic [NW-1:0]        cur_n_r;
  logic [IB-1:0]        cur_lo_r;
  logic [IB-1:0]        cur_hi_r;
  logic signed [VB-1:0] p_r;
  logic signed [VB-1:0] dd_r;
  logic signed [VB-1:0] nm_r;
  logic [1:0]           kind_r;
  logic signed [VB-1:0] ret_r;

  // walk stack of partially covered ancestors
  logic [SPW-1:0]       sp_r;
  logic [NW-1:0]        stk_n_r   [STK];
  logic [IB-1:0]        stk_lo_r  [STK];
  logic [IB-1:0]        stk_hi_r  [STK];
  logic signed [VB-1:0] stk_acc_r [STK];
  logic                 stk_ph_r  [STK];

  // memory port
  logic [NB-1:0]        rd_addr;
  logic signed [VB-1:0] rd_max;
  logic signed [VB-1:0] rd_pend;
  logic                 we_max;
  logic                 we_pend;
  logic [NB-1:0]        wr_addr;
  logic signed [VB-1:0] wd_max;
  logic signed [VB-1:0] wd_pend;

  rarmt_mem #(.DEPTH(NODES), .AW(NB), .VB(VB)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_max  (rd_max),
    .rd_pend (rd_pend),
    .we_max  (we_max),
    .we_pend (we_pend),
    .wr_addr (wr_addr),
    .wd_max  (wd_max),
    .wd_pend (wd_pend)
  );

  // derived
  logic [SPW-1:0]       top;
  logic [NW-1:0]        child0;
  logic [NW-1:0]        child1;
  logic [NW-1:0]        stk_child1;
  logic [IB:0]          cur_sum;
  logic [IB-1:0]        cur_mid;
  logic [IB:0]          stk_sum;
  logic [IB-1:0]        stk_mid;
  logic [CW-1:0]        l_c, r_c, lo_c, hi_c;
  logic                 disj, cov;
  logic signed [VB-1:0] ev_dd;
  logic signed [VB-1:0] ev_nm;
  logic signed [VB-1:0] comb;
  logic signed [VB-1:0] child_pend;
  logic signed [63:0]   d64, ret64, clamp64;
  logic [CW-1:0]        cfg_c;
  logic [IB-1:0]        li_new;

  assign top        = sp_r - SPW'(1);
  assign child0     = {cur_n_r[NW-2:0], 1'b0};
  assign child1     = {cur_n_r[NW-2:0], 1'b1};
  assign stk_child1 = {stk_n_r[top][NW-2:0], 1'b1};
  assign cur_sum    = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign cur_mid    = cur_sum[IB:1];
  assign stk_sum    = {1'b0, stk_lo_r[top]} + {1'b0, stk_hi_r[top]};
  assign stk_mid    = stk_sum[IB:1];

  assign l_c  = CW'(in_r.range_low);
  assign r_c  = CW'(in_r.range_high);
  assign lo_c = CW'(cur_lo_r);
  assign hi_c = CW'(cur_hi_r);
  assign disj = (l_c > hi_c) || (r_c < lo_c);
  assign cov  = (l_c <= lo_c) && (hi_c <= r_c);

  // an add over a fully covered node folds delta after the pending add
  assign ev_dd = (in_r.mode == rarmt_pkg::MODE_ADD && !disj && cov) ? d_r : '0;
  assign ev_nm = sat_add(sat_add(rd_max, rd_pend), ev_dd);
  assign child_pend = sat_add(sat_add(rd_pend, p_r), dd_r);
  assign comb = (stk_acc_r[top] > ret_r) ? stk_acc_r[top] : ret_r;

  // delta limited to the value range
  always_comb begin
    d64 = 64'(in_data.delta);
    if (d64 > VMAX64) begin
      d64 = VMAX64;
    end else if (d64 < VMIN64) begin
      d64 = VMIN64;
    end
  end

  always_comb begin
    ret64   = 64'(ret_r);
    clamp64 = ret64;
    if (ret64 > FMAX64) begin
      clamp64 = FMAX64;
    end else if (ret64 < FMIN64) begin
      clamp64 = FMIN64;
    end
  end

  assign cfg_c  = CW'(cfg_data);
  assign li_new = (cfg_c > CW'(SLOTS - 1)) ? IB'(SLOTS - 1) : IB'(cfg_c);

  assign busy      = (st_r != rarmt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // memory port steering
  always_comb begin
    rd_addr = cur_n_r[NB-1:0];
    we_max  = 1'b0;
    we_pend = 1'b0;
    wr_addr = cur_n_r[NB-1:0];
    wd_max  = ev_nm;
    wd_pend = '0;
    case (st_r)
      rarmt_pkg::ST_CLR: begin
        we_max  = 1'b1;
        we_pend = 1'b1;
        wr_addr = clr_r[NB-1:0];
        wd_max  = '0;
      end
      rarmt_pkg::ST_EV: begin
        we_max  = 1'b1;
        we_pend = 1'b1;
      end
      rarmt_pkg::ST_CRD0: begin
        rd_addr = child0[NB-1:0];
      end
      rarmt_pkg::ST_CWR0: begin
        we_pend = 1'b1;
        wr_addr = child0[NB-1:0];
        wd_pend = child_pend;
      end
      rarmt_pkg::ST_CRD1: begin
        rd_addr = child1[NB-1:0];
      end
      rarmt_pkg::ST_CWR1: begin
        we_pend = 1'b1;
        wr_addr = child1[NB-1:0];
        wd_pend = child_pend;
      end
      rarmt_pkg::ST_RET: begin
        // merge of both children written back on the way up (adds only)
        we_max  = (sp_r != '0) && stk_ph_r[top] && (in_r.mode == rarmt_pkg::MODE_ADD);
        wr_addr = stk_n_r[top][NB-1:0];
        wd_max  = comb;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= rarmt_pkg::ST_CLR;
      clr_r      <= '0;
      li_r       <= IB'(LI_RST);
      sp_r       <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (st_r)
        rarmt_pkg::ST_IDLE: begin
          if (start) begin
            in_r     <= in_data;
            d_r      <= VB'(d64);
            cur_n_r  <= NW'(1);
            cur_lo_r <= '0;
            cur_hi_r <= li_r;
            sp_r     <= '0;
            st_r     <= rarmt_pkg::ST_RD;
          end
        end
        rarmt_pkg::ST_CLR: begin
          clr_r <= clr_r + NW'(1);
          if (clr_r == NW'(NODES - 1)) begin
            st_r <= rarmt_pkg::ST_IDLE;
          end
        end
        rarmt_pkg::ST_RD: begin
          if (cur_n_r >= NW'(NODES)) begin
            ret_r <= VMIN;
            st_r  <= rarmt_pkg::ST_RET;
          end else begin
            st_r <= rarmt_pkg::ST_EV;
          end
        end
        rarmt_pkg::ST_EV: begin
          p_r    <= rd_pend;
          dd_r   <= ev_dd;
          nm_r   <= ev_nm;
          kind_r <= disj ? rarmt_pkg::K_DISJ : (cov ? rarmt_pkg::K_COV : rarmt_pkg::K_PART);
          if ((cur_lo_r != cur_hi_r) && ((rd_pend != '0) || (ev_dd != '0))) begin
            st_r <= rarmt_pkg::ST_CRD0;
          end else begin
            st_r <= rarmt_pkg::ST_POST;
          end
        end
        rarmt_pkg::ST_CRD0: begin
          st_r <= (child0 < NW'(NODES)) ? rarmt_pkg::ST_CWR0 : rarmt_pkg::ST_CRD1;
        end
        rarmt_pkg::ST_CWR0: begin
          st_r <= rarmt_pkg::ST_CRD1;
        end
        rarmt_pkg::ST_CRD1: begin
          st_r <= (child1 < NW'(NODES)) ? rarmt_pkg::ST_CWR1 : rarmt_pkg::ST_POST;
        end
        rarmt_pkg::ST_CWR1: begin
          st_r <= rarmt_pkg::ST_POST;
        end
        rarmt_pkg::ST_POST: begin
          case (kind_r)
            rarmt_pkg::K_DISJ: begin
              ret_r <= (in_r.mode == rarmt_pkg::MODE_QUERY) ? VMIN : nm_r;
              st_r  <= rarmt_pkg::ST_RET;
            end
            rarmt_pkg::K_COV: begin
              ret_r <= nm_r;
              st_r  <= rarmt_pkg::ST_RET;
            end
            default: begin
              stk_n_r[sp_r[SPW-1:0]]  <= cur_n_r;
              stk_lo_r[sp_r[SPW-1:0]] <= cur_lo_r;
              stk_hi_r[sp_r[SPW-1:0]] <= cur_hi_r;
              stk_ph_r[sp_r[SPW-1:0]] <= 1'b0;
              sp_r     <= sp_r + SPW'(1);
              cur_n_r  <= child0;
              cur_hi_r <= cur_mid;
              st_r     <= rarmt_pkg::ST_RD;
            end
          endcase
        end
        rarmt_pkg::ST_RET: begin
          if (sp_r == '0) begin
            out_strobe           <= 1'b1;
            out_data.answer_kind <= in_r.mode;
            out_data.max_value   <= (in_r.mode == rarmt_pkg::MODE_QUERY) ?
                                    clamp64[rarmt_pkg::FIELD_W-1:0] : '0;
            st_r                 <= rarmt_pkg::ST_IDLE;
          end else if (!stk_ph_r[top]) begin
            // left subtree done: park its value, walk the right one
            stk_acc_r[top] <= ret_r;
            stk_ph_r[top]  <= 1'b1;
            cur_n_r        <= stk_child1;
            cur_lo_r       <= stk_mid + IB'(1);
            cur_hi_r       <= stk_hi_r[top];
            st_r           <= rarmt_pkg::ST_RD;
          end else begin
            ret_r <= comb;
            sp_r  <= top;
          end
        end
        default: begin
          st_r <= rarmt_pkg::ST_IDLE;
        end
      endcase
      // a config write reshapes the tree: restart the clearing pass
      if (cfg_valid && cfg_ready) begin
        li_r  <= li_new;
        clr_r <= '0;
        st_r  <= rarmt_pkg::ST_CLR;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rarmt_checker.sv =====
// rarmt_checker: port-level assertions for range_add_range_max_tree, bound to the top level.
// Depends on: rarmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rarmt_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_strobe,
  input wire rarmt_pkg::out_t               out_data,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without a transaction in flight");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe held over two cycles");

  a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.answer_kind == rarmt_pkg::MODE_ADD) |-> out_data.max_value == '0)
    else $error("add result carries a nonzero value");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy) else $error("config write did not start clearing");

endmodule

bind range_add_range_max_tree rarmt_checker u_rarmt_checker (.*);
`default_nettype wire

// ===== dv/range_add_range_max_tree_tb.sv =====
// range_add_range_max_tree_tb: self-checking bench for the range add / range max tree.
// Holds a scoreboard class with its own lazy tree predictor, and plain driver tasks.
// Depends on: rarmt_pkg, range_add_range_max_tree.
`timescale 1ns / 1ps
module range_add_range_max_tree_tb;

  localparam int  NODES   = 2048;
  localparam longint VHI  = (64'sd1 <<< 47) - 1;
  localparam longint VLO  = -VHI - 1;
  localparam int  WDOG    = 20000;

  // Scoreboard: predicts each transaction's answer with its own lazy tree
  // and checks results in order.
  class tree_scoreboard;
    longint tree_max[NODES];
    longint tree_lazy[NODES];
    int     top_slot;
    rarmt_pkg::out_t answers[$];
    int     errors;
    int     n_adds, n_queries, n_checked;

    function void set_top_slot(int v);
      top_slot = v;
      foreach (tree_max[i]) begin
        tree_max[i]  = 0;
        tree_lazy[i] = 0;
      end
    endfunction

    function longint sat(longint a, longint b);
      longint s;
      s = a + b;
      if (s > VHI) return VHI;
      if (s < VLO) return VLO;
      return s;
    endfunction

    // fold a node's pending add into itself and hand it to both children
    function void push_down(int n, int lo, int hi);
      longint p;
      p = tree_lazy[n];
      tree_max[n] = sat(tree_max[n], p);
      if (lo != hi) begin
        if (2*n < NODES)     tree_lazy[2*n]   = sat(tree_lazy[2*n], p);
        if (2*n + 1 < NODES) tree_lazy[2*n+1] = sat(tree_lazy[2*n+1], p);
      end
      tree_lazy[n] = 0;
    endfunction

    function void range_add(int n, int lo, int hi, int l, int r, longint d);
      int     mid;
      longint m;
      if (n >= NODES) return;
      if (tree_lazy[n] != 0) push_down(n, lo, hi);
      if (l > hi || r < lo) return;
      if (l <= lo && hi <= r) begin
        tree_lazy[n] = sat(tree_lazy[n], d);
        push_down(n, lo, hi);
        return;
      end
      mid = (lo + hi) / 2;
      range_add(2*n, lo, mid, l, r, d);
      range_add(2*n + 1, mid + 1, hi, l, r, d);
      m = VLO;
      if (2*n < NODES && tree_max[2*n] > m)         m = tree_max[2*n];
      if (2*n + 1 < NODES && tree_max[2*n+1] > m)   m = tree_max[2*n+1];
      tree_max[n] = m;
    endfunction

    function longint range_max(int n, int lo, int hi, int l, int r);
      int     mid;
      longint a, b;
      if (n >= NODES) return VLO;
      push_down(n, lo, hi);
      if (l > hi || r < lo) return VLO;
      if (l <= lo && hi <= r) return tree_max[n];
      mid = (lo + hi) / 2;
      a = range_max(2*n, lo, mid, l, r);
      b = range_max(2*n + 1, mid + 1, hi, l, r);
      return (a > b) ? a : b;
    endfunction

    function void note_input(rarmt_pkg::in_t t);
      rarmt_pkg::out_t e;
      longint          mx;
      if (t.mode == rarmt_pkg::MODE_ADD) begin
        range_add(1, 0, top_slot, t.range_low, t.range_high, longint'(t.delta));
        e.answer_kind = rarmt_pkg::MODE_ADD;
        e.max_value   = '0;
        n_adds++;
      end else begin
        mx = range_max(1, 0, top_slot, t.range_low, t.range_high);
        e.answer_kind = rarmt_pkg::MODE_QUERY;
        e.max_value   = mx[rarmt_pkg::FIELD_W-1:0];
        n_queries++;
      end
      answers = {answers, e};
    endfunction

    function void check_result(rarmt_pkg::out_t got);
      rarmt_pkg::out_t e;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result kind=%0d max=%0d", $time,
                 got.answer_kind, got.max_value);
        errors++;
        return;
      end
      e = answers.pop_front();
      n_checked++;
      if (got.answer_kind !== e.answer_kind) begin
        $display("%0t: answer_kind mismatch expected=%0d actual=%0d", $time,
                 e.answer_kind, got.answer_kind);
        errors++;
      end
      if (got.max_value !== e.max_value) begin
        $display("%0t: max_value mismatch expected=%0d actual=%0d", $time,
                 e.max_value, got.max_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rarmt_pkg::in_t  in_data = '0;
  logic out_strobe;
  rarmt_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rarmt_pkg::IN_IDX_W-1:0] cfg_data = '0;

  tree_scoreboard sb;
  int  idle_cycles = 0;
  int  n_cfg = 0;
  int  top_now = 1023;

  always #5 clk = ~clk;

  range_add_range_max_tree dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Results cannot be stalled: grab every strobe at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_data);
  end

  // Watchdog: any accepted transaction, result or config write resets it.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG) begin
      $display("%0t: watchdog timeout, %0d answers pending", $time, sb.answers.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One transaction: optional random gap, then hold start until accepted.
  task automatic send(input logic m, input int l, input int r, input longint d);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.mode       = m;
    in_data.range_low  = l[rarmt_pkg::IN_IDX_W-1:0];
    in_data.range_high = r[rarmt_pkg::IN_IDX_W-1:0];
    in_data.delta      = d[rarmt_pkg::FIELD_W-1:0];
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(in_data);
    @(negedge clk);
  endtask

  // Drain: lower start and wait until every answer has come back.
  task automatic drain();
    start = 1'b0;
    while (sb.answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Config writes only when the block is idle; the write restarts the clear.
  task automatic write_top(input int v);
    drain();
    cfg_data  = v[rarmt_pkg::IN_IDX_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_top_slot(v);
    top_now = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic longint rand_delta();
    longint d;
    case ($urandom_range(0, 5))
      0: d = VHI - $urandom_range(0, 3);
      1: d = VLO + $urandom_range(0, 3);
      2, 3: d = longint'($urandom_range(0, 2000)) - 1000;
      default: begin
        d = {$urandom(), $urandom()};
        d = (d <<< 16) >>> 16;  // any 48-bit pattern, sign-extended
      end
    endcase
    return d;
  endfunction

  // Random transaction: mostly well-formed ranges inside the tree, some
  // empty, reversed or running past the top slot.
  task automatic rand_item();
    int l, r, t;
    if ($urandom_range(0, 9) == 0) begin
      l = $urandom_range(0, 1023);
      r = $urandom_range(0, 1023);
    end else begin
      l = $urandom_range(0, top_now);
      r = $urandom_range(l, top_now);
      if ($urandom_range(0, 9) == 0) begin
        t = l; l = r; r = t;
      end
    end
    send(logic'($urandom_range(0, 1)), l, r, rand_delta());
  endtask

  initial begin
    int tops[6];
    sb = new();
    sb.set_top_slot(1023);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: fresh tree, extremes of delta, saturation both ways,
    // empty and reversed ranges, ranges past the top slot, single slots.
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0);
    send(rarmt_pkg::MODE_ADD, 0, 1023, VHI);
    send(rarmt_pkg::MODE_ADD, 0, 1023, VHI);
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0);
    send(rarmt_pkg::MODE_ADD, 100, 100, VLO);
    send(rarmt_pkg::MODE_ADD, 100, 100, VLO);
    send(rarmt_pkg::MODE_ADD, 100, 100, VLO);
    send(rarmt_pkg::MODE_QUERY, 100, 100, 0);
    send(rarmt_pkg::MODE_QUERY, 99, 101, 0);
    send(rarmt_pkg::MODE_QUERY, 600, 5, 0);
    send(rarmt_pkg::MODE_ADD, 700, 3, 12345);
    send(rarmt_pkg::MODE_ADD, 1023, 1023, -1);
    send(rarmt_pkg::MODE_QUERY, 1023, 1023, 0);
    send(rarmt_pkg::MODE_ADD, 0, 0, VLO);
    send(rarmt_pkg::MODE_QUERY, 0, 511, 0);
    send(rarmt_pkg::MODE_QUERY, 512, 1023, 0);
    drain();  // sender holds off until every answer is in

    write_top(0);
    send(rarmt_pkg::MODE_ADD, 0, 1023, 7);
    send(rarmt_pkg::MODE_QUERY, 0, 0, 0);
    send(rarmt_pkg::MODE_QUERY, 1, 1023, 0);
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0);
    write_top(5);
    send(rarmt_pkg::MODE_ADD, 3, 900, -9);
    send(rarmt_pkg::MODE_QUERY, 6, 1023, 0);
    send(rarmt_pkg::MODE_QUERY, 0, 1023, 0);

    tops = '{1, 1023, 5, 300, 777, 1023};
    foreach (tops[p]) begin
      write_top(tops[p]);
      repeat (250) rand_item();
    end
    drain();
    repeat (300) @(posedge clk);

    $display("Checked %0d answers (%0d adds, %0d queries) across %0d tree sizes.",
             sb.n_checked, sb.n_adds, sb.n_queries, n_cfg + 1);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d answers missing", sb.errors, sb.answers.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== range_add_range_max_tree.f =====
hdl/rarmt_pkg.sv
hdl/rarmt_mem.sv
hdl/range_add_range_max_tree.sv
hdl/rarmt_checker.sv
dv/range_add_range_max_tree_tb.sv
